// ===== hdl/irdq_pkg.sv =====
// Shared types and constants of the image region density query block.
`timescale 1ns / 1ps
`default_nettype none
package irdq_pkg;

	localparam int DEF_MAX_WIDTH    = 256;
	localparam int DEF_MAX_HEIGHT   = 256;
	localparam int DEF_MAX_CHANNELS = 4;

	// Widths sized for an image side of up to 4096 and a channel count of up to 4.
	localparam int SIZE_W = 13;
	localparam int CHAN_W = 3;
	localparam int CNT_W  = 2 * SIZE_W + CHAN_W;
	localparam int SUM_W  = CNT_W + 8;
	localparam int DIV_W  = 64;
	localparam int BND_W  = 48;
	localparam int ADDR_W = 18;
	localparam int FQ_DEPTH = 4;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [2:0] REG_AREA_MIN_X   = 3'd0;
	localparam logic [2:0] REG_AREA_MIN_Y   = 3'd1;
	localparam logic [2:0] REG_AREA_MAX_X   = 3'd2;
	localparam logic [2:0] REG_AREA_MAX_Y   = 3'd3;
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;
	localparam logic [2:0] REG_CHANNELS     = 3'd6;

	typedef struct packed {
		logic signed [31:0] area_min_x;
		logic signed [31:0] area_min_y;
		logic signed [31:0] area_max_x;
		logic signed [31:0] area_max_y;
		logic [8:0]         image_width;
		logic [8:0]         image_height;
		logic [2:0]         channel_count;
	} cfg_t;

	typedef struct packed {
		logic               cmd;
		logic               wr_ok;
		logic [ADDR_W-1:0]  pixel_address;
		logic [7:0]         pixel_value;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
	} item_t;

	typedef struct packed {
		logic empty;
	} q_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/irdq_div.sv =====
// Bit-serial unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module irdq_div
	import irdq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      quotient
);
	localparam int CW = $clog2(DIV_W);

	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DIV_W:0]   shifted;
	logic             ge;

	assign shifted = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? shifted - {1'b0, den_q} : shifted;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== hdl/irdq_front.sv =====
// Input queue: accept items, flag writes that fall inside the store.
`timescale 1ns / 1ps
`default_nettype none
module irdq_front
	import irdq_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               cmd,
	input  wire logic [ADDR_W-1:0]  pixel_address,
	input  wire logic [7:0]         pixel_value,
	input  wire logic signed [31:0] box_min_x,
	input  wire logic signed [31:0] box_min_y,
	input  wire logic signed [31:0] box_max_x,
	input  wire logic signed [31:0] box_max_y,
	output q_ctl_t                  q_ctl_out,
	input  wire logic               q_pop,
	output item_t                   q_item
);
	localparam longint STORE_BYTES = longint'(MAX_WIDTH) * MAX_HEIGHT * MAX_CHANNELS;
	localparam int PW = $clog2(FQ_DEPTH);

	item_t         slot_q [FQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   fill_q;
	logic          do_push;
	logic          do_pop;
	item_t         in_item;

	always_comb begin
		in_item.cmd           = cmd;
		in_item.wr_ok         = 64'(pixel_address) < 64'(STORE_BYTES);
		in_item.pixel_address = pixel_address;
		in_item.pixel_value   = pixel_value;
		in_item.box_min_x     = box_min_x;
		in_item.box_min_y     = box_min_y;
		in_item.box_max_x     = box_max_x;
		in_item.box_max_y     = box_max_y;
	end

	assign full    = fill_q == (PW+1)'(FQ_DEPTH);
	assign do_push = push && !full;
	assign do_pop  = q_pop && fill_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= in_item;
	end

	assign q_ctl_out.empty = fill_q == '0;
	assign q_item          = slot_q[rd_ptr_q];
endmodule
`default_nettype wire

// ===== hdl/irdq_back.sv =====
// Execution side: pixel store, box mapping, region walk and final scaling.
`timescale 1ns / 1ps
`default_nettype none
module irdq_back
	import irdq_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire q_ctl_t q_ctl,
	output logic       q_pop,
	input  wire item_t q_item,
	output logic       empty,
	input  wire logic  pop,
	output logic [15:0] density,
	output logic [18:0] sample_count
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RL_W  = SIZE_W + CHAN_W;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_DSTART, S_DWAIT, S_CLAMP, S_ADDR1, S_ADDR2,
		S_WALK, S_DRAIN, S_FIN, S_FWAIT, S_OUT
	} state_t;

	state_t state_q;
	item_t  item_q;
	logic [1:0] j_q;
	logic signed [BND_W-1:0] prod_q;
	logic signed [BND_W-1:0] bnd_q [4];
	logic [SIZE_W-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [2*SIZE_W-1:0] t_q;
	logic [AW-1:0] wc_q, ptr_q, rowstart_q;
	logic [RL_W-1:0] rowlen_q, col_q;
	logic [SIZE_W-1:0] rows_left_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic rd_v_s1;
	logic [7:0] rd_data_s1;
	logic res_valid_q;
	logic [15:0] quo_fin_q;
	logic [15:0] density_q;
	logic [18:0] count_out_q;
	logic [7:0] mem [DEPTH];

	logic [SIZE_W-1:0] w_c, h_c;
	logic [CHAN_W-1:0] c_c;
	logic signed [32:0] dx, dy;
	logic [31:0] ext_x, ext_y, ext_j;
	logic signed [31:0] box_j, amin_j;
	logic [SIZE_W-1:0] size_j;
	logic signed [33:0] num_j;
	logic signed [BND_W-1:0] prod_d;
	logic [BND_W-1:0] mag;
	logic div_start, div_done;
	logic [DIV_W-1:0] div_num, div_den, div_q;
	logic signed [BND_W:0] x0s, x1s, y0s, y1s, wm1, hm1, sx, sy, mx, my;
	logic empty_rect;
	logic wr_en, rd_en, do_pop, out_load;

	always_comb begin
		if (cfg.image_width == '0) w_c = SIZE_W'(1);
		else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) w_c = SIZE_W'(MAX_WIDTH);
		else w_c = SIZE_W'(cfg.image_width);
		if (cfg.image_height == '0) h_c = SIZE_W'(1);
		else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) h_c = SIZE_W'(MAX_HEIGHT);
		else h_c = SIZE_W'(cfg.image_height);
		if (cfg.channel_count == '0) c_c = CHAN_W'(1);
		else if (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) c_c = CHAN_W'(MAX_CHANNELS);
		else c_c = CHAN_W'(cfg.channel_count);
		dx = 33'(cfg.area_max_x) - 33'(cfg.area_min_x);
		dy = 33'(cfg.area_max_y) - 33'(cfg.area_min_y);
		ext_x = (dx < 33'sd1) ? 32'd1 : dx[31:0];
		ext_y = (dy < 33'sd1) ? 32'd1 : dy[31:0];
	end

	// Bound j: 0 low x, 1 high x, 2 low y, 3 high y.
	always_comb begin
		box_j  = j_q[0] ? (j_q[1] ? item_q.box_max_y : item_q.box_max_x)
		                : (j_q[1] ? item_q.box_min_y : item_q.box_min_x);
		amin_j = j_q[1] ? cfg.area_min_y : cfg.area_min_x;
		ext_j  = j_q[1] ? ext_y : ext_x;
		size_j = j_q[1] ? h_c : w_c;
		num_j  = 34'(box_j) - 34'(amin_j) + (j_q[0] ? 34'sd1 : -34'sd1);
		prod_d = BND_W'(num_j) * BND_W'($signed({1'b0, size_j}));
		mag    = prod_q[BND_W-1] ? BND_W'(-prod_q) : BND_W'(prod_q);
	end

	always_comb begin
		wm1 = (BND_W+1)'($signed({1'b0, w_c})) - 1;
		hm1 = (BND_W+1)'($signed({1'b0, h_c})) - 1;
		x0s = bnd_q[0] < 0 ? '0 : (BND_W+1)'(bnd_q[0]);
		x1s = (BND_W+1)'(bnd_q[1]) > wm1 ? wm1 : (BND_W+1)'(bnd_q[1]);
		y0s = bnd_q[2] < 0 ? '0 : (BND_W+1)'(bnd_q[2]);
		y1s = (BND_W+1)'(bnd_q[3]) > hm1 ? hm1 : (BND_W+1)'(bnd_q[3]);
		empty_rect = (x0s > x1s) || (y0s > y1s);
		// Midpoint, truncated toward zero, then clamped into the image.
		sx = (BND_W+1)'(bnd_q[0]) + (BND_W+1)'(bnd_q[1]);
		sy = (BND_W+1)'(bnd_q[2]) + (BND_W+1)'(bnd_q[3]);
		sx = (sx + $signed((BND_W+1)'(sx[BND_W]))) >>> 1;
		sy = (sy + $signed((BND_W+1)'(sy[BND_W]))) >>> 1;
		mx = sx < 0 ? '0 : (sx > wm1 ? wm1 : sx);
		my = sy < 0 ? '0 : (sy > hm1 ? hm1 : sy);
	end

	assign div_start = (state_q == S_DSTART) || (state_q == S_FIN);
	always_comb begin
		if (state_q == S_FIN) begin
			div_num = DIV_W'({sum_q, 16'h0000}) - DIV_W'(sum_q);
			div_den = DIV_W'({count_q, 8'h00}) - DIV_W'(count_q);
		end else begin
			div_num = DIV_W'(mag);
			div_den = DIV_W'(ext_j);
		end
	end

	irdq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_q)
	);

	assign do_pop   = (state_q == S_IDLE) && !q_ctl.empty;
	assign q_pop    = do_pop;
	assign wr_en    = do_pop && q_item.cmd == CMD_WRITE && q_item.wr_ok;
	assign rd_en    = state_q == S_WALK;
	assign out_load = (state_q == S_OUT) && (!res_valid_q || pop);

	always_ff @(posedge clk) begin
		if (wr_en) mem[AW'(q_item.pixel_address)] <= q_item.pixel_value;
		if (rd_en) rd_data_s1 <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			rd_v_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (rd_v_s1) sum_q <= sum_q + SUM_W'(rd_data_s1);
			if (out_load) begin
				res_valid_q <= 1'b1;
				density_q   <= 16'hFFFF - quo_fin_q;
				count_out_q <= count_q[18:0];
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (do_pop) begin
						item_q <= q_item;
						j_q    <= '0;
						if (q_item.cmd == CMD_QUERY) state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= prod_d;
					state_q <= S_DSTART;
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) begin
						bnd_q[j_q] <= prod_q[BND_W-1] ? -$signed(div_q[BND_W-1:0])
						                              : $signed(div_q[BND_W-1:0]);
						j_q     <= j_q + 1'b1;
						state_q <= (j_q == 2'd3) ? S_CLAMP : S_MUL;
					end
				end
				S_CLAMP: begin
					x0_q    <= SIZE_W'(empty_rect ? mx : x0s);
					x1_q    <= SIZE_W'(empty_rect ? mx : x1s);
					y0_q    <= SIZE_W'(empty_rect ? my : y0s);
					y1_q    <= SIZE_W'(empty_rect ? my : y1s);
					state_q <= S_ADDR1;
				end
				S_ADDR1: begin
					t_q         <= (2*SIZE_W)'(h_c - 1'b1 - y0_q) * (2*SIZE_W)'(w_c);
					wc_q        <= AW'(32'(w_c) * 32'(c_c));
					rowlen_q    <= RL_W'(x1_q - x0_q + 1'b1) * RL_W'(c_c);
					rows_left_q <= y1_q - y0_q;
					state_q     <= S_ADDR2;
				end
				S_ADDR2: begin
					ptr_q      <= AW'(CNT_W'(t_q + (2*SIZE_W)'(x0_q)) * CNT_W'(c_c));
					rowstart_q <= AW'(CNT_W'(t_q + (2*SIZE_W)'(x0_q)) * CNT_W'(c_c));
					count_q    <= CNT_W'(rowlen_q) * CNT_W'(rows_left_q + 1'b1);
					sum_q      <= '0;
					col_q      <= '0;
					state_q    <= S_WALK;
				end
				S_WALK: begin
					// Bytes of one row are contiguous; next row sits one stride lower.
					if (col_q == rowlen_q - 1'b1) begin
						col_q <= '0;
						if (rows_left_q == '0) begin
							state_q <= S_DRAIN;
						end else begin
							rows_left_q <= rows_left_q - 1'b1;
							rowstart_q  <= rowstart_q - wc_q;
							ptr_q       <= rowstart_q - wc_q;
						end
					end else begin
						col_q <= col_q + 1'b1;
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_FIN;
				S_FIN: state_q <= S_FWAIT;
				S_FWAIT: begin
					if (div_done) begin
						quo_fin_q <= div_q[15:0];
						state_q   <= S_OUT;
					end
				end
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign empty        = !res_valid_q;
	assign density      = density_q;
	assign sample_count = count_out_q;
endmodule
`default_nettype wire

// ===== hdl/image_region_density_query.sv =====
// Top level of the image region density query block.
`timescale 1ns / 1ps
`default_nettype none
// The block holds a byte image (interleaved channels) and answers darkness
// queries over a box given in model coordinates. Load items (cmd 0) write one
// byte and leave no result; query items (cmd 1) return one beat with density
// (65535 minus the scaled mean, Q0.16) and sample_count. Items enter a
// four-deep queue and are carried out one at a time. A query first maps the
// box, one bound after another, each through a multiply and the one shared
// bit-serial divider; it then sets up the region walk, reads one channel byte
// of the region per cycle (one read port of the pixel memory), and ends with
// the final scaling divide. The pixel memory is not cleared: query only bytes
// that were loaded. Write configuration only while idle.
module image_region_density_query
	import irdq_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               cmd,
	input  wire logic [ADDR_W-1:0]  pixel_address,
	input  wire logic [7:0]         pixel_value,
	input  wire logic signed [31:0] box_min_x,
	input  wire logic signed [31:0] box_min_y,
	input  wire logic signed [31:0] box_max_x,
	input  wire logic signed [31:0] box_max_y,
	output logic                    empty,
	input  wire logic               pop,
	output logic [15:0]             density,
	output logic [18:0]             sample_count,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	cfg_t   cfg_q;
	q_ctl_t q_ctl;
	item_t  q_item;
	logic   q_pop;

	// Configuration is always taken; unknown indexes drop the beat.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area_min_x    <= 32'sd0;
			cfg_q.area_min_y    <= 32'sd0;
			cfg_q.area_max_x    <= 32'sd1;
			cfg_q.area_max_y    <= 32'sd1;
			cfg_q.image_width   <= 9'd1;
			cfg_q.image_height  <= 9'd1;
			cfg_q.channel_count <= 3'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_AREA_MIN_X:   cfg_q.area_min_x    <= cfg_data;
				REG_AREA_MIN_Y:   cfg_q.area_min_y    <= cfg_data;
				REG_AREA_MAX_X:   cfg_q.area_max_x    <= cfg_data;
				REG_AREA_MAX_Y:   cfg_q.area_max_y    <= cfg_data;
				REG_IMAGE_WIDTH:  cfg_q.image_width   <= cfg_data[8:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height  <= cfg_data[8:0];
				REG_CHANNELS:     cfg_q.channel_count <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Front: accept and classify beats into the item queue.
	irdq_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.box_min_x     (box_min_x),
		.box_min_y     (box_min_y),
		.box_max_x     (box_max_x),
		.box_max_y     (box_max_y),
		.q_ctl_out     (q_ctl),
		.q_pop         (q_pop),
		.q_item        (q_item)
	);

	// Back: store loads, walk query regions, hold the result beat.
	irdq_back #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_ctl        (q_ctl),
		.q_pop        (q_pop),
		.q_item       (q_item),
		.empty        (empty),
		.pop          (pop),
		.density      (density),
		.sample_count (sample_count)
	);
endmodule
`default_nettype wire
